// File: hw/rtl/qbe_pkg.sv
// Package for the quintic Bezier evaluator: register index codes and the
// fixed Bernstein coefficients. No dependencies.
`default_nettype none

package qbe_pkg;

    localparam int NUM_POINTS      = 6;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 64;
    localparam int HALF_LSB_POS    = 32;   // x half starts at this bit
    localparam int COEF_WIDTH      = 7;    // headroom for coefficients up to 60

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_START_POINT      = 3'd0,
        REG_CTRL_POINT_ONE   = 3'd1,
        REG_CTRL_POINT_TWO   = 3'd2,
        REG_CTRL_POINT_THREE = 3'd3,
        REG_CTRL_POINT_FOUR  = 3'd4,
        REG_FINISH_POINT     = 3'd5
    } cfg_reg_t;

    // Binomials for the curve, and scaled ones for the two derivatives
    localparam int BINOM5     [6] = '{1, 5, 10, 10, 5, 1};
    localparam int SLOPE_COEF [5] = '{5, 20, 30, 20, 5};
    localparam int BEND_COEF  [4] = '{20, 60, 60, 20};

endpackage : qbe_pkg

`default_nettype wire

// File: hw/rtl/qbe_if.sv
// Channel interfaces of the quintic Bezier evaluator: parameter words,
// result words and configuration writes. Depends on qbe_pkg.
`default_nettype none

interface qbe_t_if #(
    parameter int T_FRAC_BITS = 16
) ();
    logic                 valid;
    logic                 ready;
    logic [T_FRAC_BITS:0] t_param;

    modport source (output valid, output t_param, input ready);
    modport sink   (input valid, input t_param, output ready);
endinterface : qbe_t_if

interface qbe_res_if #(
    parameter int COORD_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH+7:0] slope_x;
    logic signed [COORD_WIDTH+7:0] slope_y;
    logic signed [COORD_WIDTH+9:0] bend_x;
    logic signed [COORD_WIDTH+9:0] bend_y;

    modport source (output valid, output point_x, output point_y, output slope_x,
                    output slope_y, output bend_x, output bend_y, input ready);
    modport sink   (input valid, input point_x, input point_y, input slope_x,
                    input slope_y, input bend_x, input bend_y, output ready);
endinterface : qbe_res_if

interface qbe_cfg_if ();
    import qbe_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : qbe_cfg_if

`default_nettype wire

// File: hw/rtl/qbe_basis.sv
// Basis pipeline: clamps t, builds powers of t and 1-t, and forms the scaled
// Bernstein weights for point, slope and bend. Depends on qbe_pkg.
`default_nettype none

module qbe_basis #(
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [T_FRAC_BITS:0]                   in_t,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [T_FRAC_BITS+qbe_pkg::COEF_WIDTH:0]    w_point [6],
    output logic [T_FRAC_BITS+qbe_pkg::COEF_WIDTH:0]    w_slope [5],
    output logic [T_FRAC_BITS+qbe_pkg::COEF_WIDTH:0]    w_bend  [4]
);
    import qbe_pkg::*;

    localparam int TW   = T_FRAC_BITS + 1;
    localparam int WW   = TW + COEF_WIDTH;
    localparam int NSTG = 6;
    localparam logic [TW-1:0]   T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam logic [2*TW-1:0] Q_HALF =
        {{(2*TW-T_FRAC_BITS){1'b0}}, 1'b1, {(T_FRAC_BITS-1){1'b0}}};

    // Q0.F product rounded half up; never exceeds one, so TW bits hold it
    function automatic logic [TW-1:0] qmul(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [2*TW-1:0] p;
        p = {{TW{1'b0}}, a} * {{TW{1'b0}}, b} + Q_HALF;
        return p[T_FRAC_BITS +: TW];
    endfunction

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] ready;

    logic [TW-1:0] st1_t_reg, st1_u_reg, st1_t_next;
    logic [TW-1:0] st2_t_reg, st2_u_reg, st2_t2_reg, st2_u2_reg;
    logic [TW-1:0] st3_tp_reg [1:3];
    logic [TW-1:0] st3_up_reg [1:3];
    logic [TW-1:0] st4_tp_reg [1:4];
    logic [TW-1:0] st4_up_reg [1:4];
    logic [TW-1:0] st5_wp_reg [6];
    logic [TW-1:0] st5_ws_reg [5];
    logic [TW-1:0] st5_wb_reg [4];
    logic [WW-1:0] st6_wp_reg [6];
    logic [WW-1:0] st6_ws_reg [5];
    logic [WW-1:0] st6_wb_reg [4];

    // Stall chain: a stage moves when it is empty or the next one moves
    always_comb
    begin
        ready[NSTG-1] = !valid_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    assign in_ready  = ready[0];
    assign out_valid = valid_reg[NSTG-1];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (ready[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Saturate t to one
    assign st1_t_next = (in_t > T_ONE) ? T_ONE : in_t;

    // Stage 1: t and u = 1 - t
    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            st1_t_reg <= st1_t_next;
            st1_u_reg <= T_ONE - st1_t_next;
        end
    end

    // Stage 2: squares
    always_ff @(posedge clk)
    begin
        if (ready[1])
        begin
            st2_t_reg  <= st1_t_reg;
            st2_u_reg  <= st1_u_reg;
            st2_t2_reg <= qmul(st1_t_reg, st1_t_reg);
            st2_u2_reg <= qmul(st1_u_reg, st1_u_reg);
        end
    end

    // Stage 3: cubes
    always_ff @(posedge clk)
    begin
        if (ready[2])
        begin
            st3_tp_reg[1] <= st2_t_reg;
            st3_tp_reg[2] <= st2_t2_reg;
            st3_tp_reg[3] <= qmul(st2_t2_reg, st2_t_reg);
            st3_up_reg[1] <= st2_u_reg;
            st3_up_reg[2] <= st2_u2_reg;
            st3_up_reg[3] <= qmul(st2_u2_reg, st2_u_reg);
        end
    end

    // Stage 4: fourth powers, each from the rounded cube
    always_ff @(posedge clk)
    begin
        if (ready[3])
        begin
            for (int k = 1; k < 4; k++)
            begin
                st4_tp_reg[k] <= st3_tp_reg[k];
                st4_up_reg[k] <= st3_up_reg[k];
            end
            st4_tp_reg[4] <= qmul(st3_tp_reg[3], st3_tp_reg[1]);
            st4_up_reg[4] <= qmul(st3_up_reg[3], st3_up_reg[1]);
        end
    end

    // Stage 5: unscaled Bernstein products t^k * u^m
    always_ff @(posedge clk)
    begin
        if (ready[4])
        begin
            st5_wp_reg[0] <= qmul(st4_up_reg[4], st4_up_reg[1]);
            st5_wp_reg[1] <= qmul(st4_tp_reg[1], st4_up_reg[4]);
            st5_wp_reg[2] <= qmul(st4_tp_reg[2], st4_up_reg[3]);
            st5_wp_reg[3] <= qmul(st4_tp_reg[3], st4_up_reg[2]);
            st5_wp_reg[4] <= qmul(st4_tp_reg[4], st4_up_reg[1]);
            st5_wp_reg[5] <= qmul(st4_tp_reg[4], st4_tp_reg[1]);
            st5_ws_reg[0] <= st4_up_reg[4];
            st5_ws_reg[1] <= qmul(st4_tp_reg[1], st4_up_reg[3]);
            st5_ws_reg[2] <= qmul(st4_tp_reg[2], st4_up_reg[2]);
            st5_ws_reg[3] <= qmul(st4_tp_reg[3], st4_up_reg[1]);
            st5_ws_reg[4] <= st4_tp_reg[4];
            st5_wb_reg[0] <= st4_up_reg[3];
            st5_wb_reg[1] <= qmul(st4_tp_reg[1], st4_up_reg[2]);
            st5_wb_reg[2] <= qmul(st4_tp_reg[2], st4_up_reg[1]);
            st5_wb_reg[3] <= st4_tp_reg[3];
        end
    end

    // Stage 6: scale by the fixed coefficients
    always_ff @(posedge clk)
    begin
        if (ready[5])
        begin
            for (int k = 0; k < 6; k++)
            begin
                st6_wp_reg[k] <= WW'(BINOM5[k]) * {{COEF_WIDTH{1'b0}}, st5_wp_reg[k]};
            end
            for (int k = 0; k < 5; k++)
            begin
                st6_ws_reg[k] <= WW'(SLOPE_COEF[k]) * {{COEF_WIDTH{1'b0}}, st5_ws_reg[k]};
            end
            for (int k = 0; k < 4; k++)
            begin
                st6_wb_reg[k] <= WW'(BEND_COEF[k]) * {{COEF_WIDTH{1'b0}}, st5_wb_reg[k]};
            end
        end
    end

    assign w_point = st6_wp_reg;
    assign w_slope = st6_ws_reg;
    assign w_bend  = st6_wb_reg;

    // t is clamped and u complements it
    a_t_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] |-> (st1_t_reg <= T_ONE) && (TW'(st1_t_reg + st1_u_reg) == T_ONE))
        else $error("t/u pair out of range");

    // Raw end Bernstein products (u^5 and t^5) never exceed one
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[4] |-> (st5_wp_reg[0] <= T_ONE) && (st5_wp_reg[5] <= T_ONE))
        else $error("end weight above one");

endmodule : qbe_basis

`default_nettype wire

// File: hw/rtl/qbe_combine.sv
// Combine pipeline: multiplies weights by control points and their
// differences, sums, rounds and saturates. Depends on qbe_pkg.
`default_nettype none

module qbe_combine #(
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        in_valid,
    output logic                                             in_ready,
    input  wire logic [T_FRAC_BITS+qbe_pkg::COEF_WIDTH:0]    w_point [6],
    input  wire logic [T_FRAC_BITS+qbe_pkg::COEF_WIDTH:0]    w_slope [5],
    input  wire logic [T_FRAC_BITS+qbe_pkg::COEF_WIDTH:0]    w_bend  [4],
    input  wire logic signed [COORD_WIDTH-1:0]               px [6],
    input  wire logic signed [COORD_WIDTH-1:0]               py [6],
    output logic                                             out_valid,
    input  wire logic                                        out_ready,
    output logic signed [COORD_WIDTH-1:0]                    point_x,
    output logic signed [COORD_WIDTH-1:0]                    point_y,
    output logic signed [COORD_WIDTH+7:0]                    slope_x,
    output logic signed [COORD_WIDTH+7:0]                    slope_y,
    output logic signed [COORD_WIDTH+9:0]                    bend_x,
    output logic signed [COORD_WIDTH+9:0]                    bend_y
);
    import qbe_pkg::*;

    localparam int WW   = T_FRAC_BITS + 1 + COEF_WIDTH;
    localparam int DW   = COORD_WIDTH + 2;
    localparam int PW   = WW + 1 + DW;
    localparam int AW   = PW + 3;
    localparam int SW   = AW - T_FRAC_BITS;
    localparam int PT_W = COORD_WIDTH;
    localparam int SL_W = COORD_WIDTH + 8;
    localparam int BD_W = COORD_WIDTH + 10;
    localparam int NSTG = 4;
    localparam logic signed [AW-1:0] A_HALF =
        {{(AW-T_FRAC_BITS){1'b0}}, 1'b1, {(T_FRAC_BITS-1){1'b0}}};
    localparam logic signed [SW-1:0] PT_MAX = {{(SW-PT_W+1){1'b0}}, {(PT_W-1){1'b1}}};
    localparam logic signed [SW-1:0] SL_MAX = {{(SW-SL_W+1){1'b0}}, {(SL_W-1){1'b1}}};
    localparam logic signed [SW-1:0] BD_MAX = {{(SW-BD_W+1){1'b0}}, {(BD_W-1){1'b1}}};

    function automatic logic [PT_W-1:0] sat_pt(input logic signed [SW-1:0] v);
        if (v > PT_MAX)
            return PT_MAX[PT_W-1:0];
        else if (v < ~PT_MAX)
            return ~PT_MAX[PT_W-1:0];
        else
            return v[PT_W-1:0];
    endfunction

    function automatic logic [SL_W-1:0] sat_sl(input logic signed [SW-1:0] v);
        if (v > SL_MAX)
            return SL_MAX[SL_W-1:0];
        else if (v < ~SL_MAX)
            return ~SL_MAX[SL_W-1:0];
        else
            return v[SL_W-1:0];
    endfunction

    function automatic logic [BD_W-1:0] sat_bd(input logic signed [SW-1:0] v);
        if (v > BD_MAX)
            return BD_MAX[BD_W-1:0];
        else if (v < ~BD_MAX)
            return ~BD_MAX[BD_W-1:0];
        else
            return v[BD_W-1:0];
    endfunction

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] ready;

    // [axis][kind][term]; kind 0 point, 1 slope, 2 bend
    logic signed [COORD_WIDTH-1:0] coord [2][6];
    logic signed [DW-1:0]          diff  [2][3][6];
    logic [WW-1:0]                 wgt   [3][6];
    logic signed [PW-1:0]          prod_next [2][3][6];
    logic signed [PW-1:0]          prod_reg  [2][3][6];
    logic signed [AW-1:0]          pair_reg  [2][3][3];
    logic signed [AW-1:0]          acc_reg   [2][3];
    logic signed [PT_W-1:0]        pt_reg [2];
    logic signed [SL_W-1:0]        sl_reg [2];
    logic signed [BD_W-1:0]        bd_reg [2];

    // Stall chain
    always_comb
    begin
        ready[NSTG-1] = !valid_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    assign in_ready  = ready[0];
    assign out_valid = valid_reg[NSTG-1];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (ready[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Operands: points, first and second differences, with their weights
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            coord[0][k] = px[k];
            coord[1][k] = py[k];
            wgt[0][k]   = w_point[k];
            wgt[1][k]   = '0;
            wgt[2][k]   = '0;
        end
        for (int k = 0; k < 5; k++)
        begin
            wgt[1][k] = w_slope[k];
        end
        for (int k = 0; k < 4; k++)
        begin
            wgt[2][k] = w_bend[k];
        end
        for (int a = 0; a < 2; a++)
        begin
            for (int k = 0; k < 6; k++)
            begin
                diff[a][0][k] = {{2{coord[a][k][COORD_WIDTH-1]}}, coord[a][k]};
                diff[a][1][k] = '0;
                diff[a][2][k] = '0;
            end
            for (int k = 0; k < 5; k++)
            begin
                diff[a][1][k] = diff[a][0][k+1] - diff[a][0][k];
            end
            for (int k = 0; k < 4; k++)
            begin
                diff[a][2][k] = diff[a][0][k] - (diff[a][0][k+1] <<< 1) + diff[a][0][k+2];
            end
            for (int d = 0; d < 3; d++)
            begin
                for (int k = 0; k < 6; k++)
                begin
                    prod_next[a][d][k] = $signed({1'b0, wgt[d][k]}) * diff[a][d][k];
                end
            end
        end
    end

    // Stage 1: products
    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            prod_reg <= prod_next;
        end
    end

    // Stage 2: pairwise sums
    always_ff @(posedge clk)
    begin
        if (ready[1])
        begin
            for (int a = 0; a < 2; a++)
            begin
                for (int d = 0; d < 3; d++)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        pair_reg[a][d][j] <= AW'(prod_reg[a][d][2*j])
                                           + AW'(prod_reg[a][d][2*j+1]);
                    end
                end
            end
        end
    end

    // Stage 3: final sum plus rounding half
    always_ff @(posedge clk)
    begin
        if (ready[2])
        begin
            for (int a = 0; a < 2; a++)
            begin
                for (int d = 0; d < 3; d++)
                begin
                    acc_reg[a][d] <= pair_reg[a][d][0] + pair_reg[a][d][1]
                                   + pair_reg[a][d][2] + A_HALF;
                end
            end
        end
    end

    // Stage 4: drop fraction bits and saturate into the output word
    always_ff @(posedge clk)
    begin
        if (ready[3])
        begin
            for (int a = 0; a < 2; a++)
            begin
                pt_reg[a] <= sat_pt(acc_reg[a][0][AW-1:T_FRAC_BITS]);
                sl_reg[a] <= sat_sl(acc_reg[a][1][AW-1:T_FRAC_BITS]);
                bd_reg[a] <= sat_bd(acc_reg[a][2][AW-1:T_FRAC_BITS]);
            end
        end
    end

    assign point_x = pt_reg[0];
    assign point_y = pt_reg[1];
    assign slope_x = sl_reg[0];
    assign slope_y = sl_reg[1];
    assign bend_x  = bd_reg[0];
    assign bend_y  = bd_reg[1];

    // A stalled output word is not replaced
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NSTG-1] && !out_ready |=> valid_reg[NSTG-1] && $stable(pt_reg[0]))
        else $error("output word overwritten under stall");

endmodule : qbe_combine

`default_nettype wire

// File: hw/rtl/quintic_bezier_evaluator_top.sv
// Top level of the quintic Bezier evaluator: control point registers and
// the two pipeline halves. Depends on qbe_pkg, qbe_if, qbe_basis, qbe_combine.
//
// Usage:
//   cfg    - write word: index 0..5 selects start point, four inner points,
//            finish point; data holds x in bits 63:32 and y in bits 31:0.
//            Always ready; indexes above five are dropped. Write only when idle.
//   sample - one t word (unsigned Q1.F, values above one read as one).
//   result - point, slope and bend of the curve at that t.
// From an accepted sample to its result word, six stages form the
// Bernstein weights and four multiply, sum, round and saturate. While the
// receiver does not stall, one word per cycle, set by the fully pipelined multipliers.
// When the receiver stalls, each stage holds; empty stages still take words,
// so the input stays ready until the pipeline has filled.
// Reset empties the pipeline and clears all control points to zero.
`default_nettype none

module quintic_bezier_evaluator_top #(
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    qbe_cfg_if.sink   cfg,
    qbe_t_if.sink     sample,
    qbe_res_if.source result
);
    import qbe_pkg::*;

    localparam int WW = T_FRAC_BITS + 1 + COEF_WIDTH;

    logic [CFG_DATA_WIDTH-1:0]     point_reg [NUM_POINTS];
    logic signed [COORD_WIDTH-1:0] px [NUM_POINTS];
    logic signed [COORD_WIDTH-1:0] py [NUM_POINTS];
    logic [WW-1:0]                 w_point [6];
    logic [WW-1:0]                 w_slope [5];
    logic [WW-1:0]                 w_bend  [4];
    logic                          basis_valid;
    logic                          basis_ready;

    assign cfg.ready = 1'b1;

    // Write control point registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                point_reg[i] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_START_POINT:      point_reg[0] <= cfg.data;
                REG_CTRL_POINT_ONE:   point_reg[1] <= cfg.data;
                REG_CTRL_POINT_TWO:   point_reg[2] <= cfg.data;
                REG_CTRL_POINT_THREE: point_reg[3] <= cfg.data;
                REG_CTRL_POINT_FOUR:  point_reg[4] <= cfg.data;
                REG_FINISH_POINT:     point_reg[5] <= cfg.data;
                default:              ;
            endcase
        end
    end

    // Split each register into x and y coordinates
    always_comb
    begin
        for (int i = 0; i < NUM_POINTS; i++)
        begin
            px[i] = point_reg[i][HALF_LSB_POS +: COORD_WIDTH];
            py[i] = point_reg[i][0 +: COORD_WIDTH];
        end
    end

    qbe_basis #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_basis (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .in_t      (sample.t_param),
        .out_valid (basis_valid),
        .out_ready (basis_ready),
        .w_point   (w_point),
        .w_slope   (w_slope),
        .w_bend    (w_bend)
    );

    qbe_combine #(
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (basis_valid),
        .in_ready  (basis_ready),
        .w_point   (w_point),
        .w_slope   (w_slope),
        .w_bend    (w_bend),
        .px        (px),
        .py        (py),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .point_x   (result.point_x),
        .point_y   (result.point_y),
        .slope_x   (result.slope_x),
        .slope_y   (result.slope_y),
        .bend_x    (result.bend_x),
        .bend_y    (result.bend_y)
    );

    // Out-of-range index leaves control points untouched; checked on the start and finish points
    a_cfg_ignore: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && (cfg.index > REG_FINISH_POINT)
        |=> $stable(point_reg[0]) && $stable(point_reg[5]))
        else $error("stray configuration write landed");

    // With no word waiting at the output, the input is never blocked
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> sample.ready)
        else $error("input stalled with empty output");

endmodule : quintic_bezier_evaluator_top

`default_nettype wire

// File: test/tb.sv
// Testbench for the quintic Bezier evaluator: directed table then random t words,
// checked against a fixed-point predictor. Depends on qbe_pkg, qbe_if and the RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qbe_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam longint T_ONE = 64'd1 << FB;
    localparam longint T_HALF = 64'd1 << (FB - 1);
    localparam int LATENCY = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS = 2000;
    localparam int PHASES = 8;

    typedef struct {
        logic signed [CW-1:0] px, py;
        logic signed [CW+7:0] sx, sy;
        logic signed [CW+9:0] bx, by;
    } curve_sample_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   failed = 1'b0;
    bit   quiet = 1'b0;       // no idling in the last part
    int   idle_cycles = 0;

    logic [63:0]   ctrl_pts [NUM_POINTS];
    curve_sample_t expected_samples [$];

    qbe_cfg_if           cfg ();
    qbe_t_if   #(FB)     sample ();
    qbe_res_if #(CW)     result ();

    quintic_bezier_evaluator_top #(.COORD_WIDTH(CW), .T_FRAC_BITS(FB)) uut (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .sample(sample), .result(result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Round half up to Q0.F
    function automatic longint unsigned frac_mul(longint unsigned a, longint unsigned b);
        return (a * b + T_HALF) >> FB;
    endfunction

    function automatic longint coord_of(logic [63:0] r, bit y_axis);
        logic [31:0] h;
        h = y_axis ? r[31:0] : r[63:32];
        return longint'($signed(h));
    endfunction

    function automatic longint round_q(longint v);
        return (v + T_HALF) >>> FB;
    endfunction

    function automatic longint clamp(longint v, int bits);
        longint hi;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // Point, slope and bend of the curve at t
    function automatic curve_sample_t eval_curve(logic [FB:0] t_in);
        longint unsigned t, u;
        longint unsigned tp [6], up [6];
        longint p [6];
        longint acc0, acc1, acc2, w;
        curve_sample_t s;
        t = (t_in > T_ONE) ? T_ONE : 64'(t_in);
        u = T_ONE - t;
        tp[0] = T_ONE;
        up[0] = T_ONE;
        for (int k = 1; k < 6; k++)
        begin
            tp[k] = frac_mul(tp[k-1], t);
            up[k] = frac_mul(up[k-1], u);
        end
        for (int ax = 0; ax < 2; ax++)
        begin
            for (int k = 0; k < 6; k++) p[k] = coord_of(ctrl_pts[k], ax == 1);
            acc0 = 0; acc1 = 0; acc2 = 0;
            for (int k = 0; k < 6; k++)
            begin
                w = BINOM5[k] * longint'(frac_mul(tp[k], up[5-k]));
                acc0 += w * p[k];
            end
            for (int k = 0; k < 5; k++)
            begin
                w = SLOPE_COEF[k] * longint'(frac_mul(tp[k], up[4-k]));
                acc1 += w * (p[k+1] - p[k]);
            end
            for (int k = 0; k < 4; k++)
            begin
                w = BEND_COEF[k] * longint'(frac_mul(tp[k], up[3-k]));
                acc2 += w * (p[k] - 2 * p[k+1] + p[k+2]);
            end
            if (ax == 0)
            begin
                s.px = CW'(clamp(round_q(acc0), CW));
                s.sx = (CW+8)'(clamp(round_q(acc1), CW + 8));
                s.bx = (CW+10)'(clamp(round_q(acc2), CW + 10));
            end
            else
            begin
                s.py = CW'(clamp(round_q(acc0), CW));
                s.sy = (CW+8)'(clamp(round_q(acc1), CW + 8));
                s.by = (CW+10)'(clamp(round_q(acc2), CW + 10));
            end
        end
        return s;
    endfunction

    task automatic idle_burst();
        if (!quiet && $urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) @(negedge clk);
    endtask

    // Write one register; valid is dropped and held low before returning, so valid is not driven twice at once
    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [63:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        if (idx < NUM_POINTS) ctrl_pts[idx] = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Send one t word; valid stays high across back-to-back words unless a random gap drops it
    task automatic send_t(logic [FB:0] t);
        sample.valid   <= 1'b1;
        sample.t_param <= t;
        do @(posedge clk); while (!sample.ready);
        expected_samples.insert(expected_samples.size(), eval_curve(t));
        @(negedge clk);
        if (!quiet && $urandom_range(3) == 0)
        begin
            sample.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
    endtask

    task automatic drain();
        sample.valid <= 1'b0;
        while (expected_samples.size() != 0) @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    function automatic logic [63:0] random_point(int mode);
        logic [31:0] hx, hy;
        case (mode)
            0: begin hx = $urandom; hy = $urandom; end
            1: begin hx = 32'h7fff_ffff; hy = 32'h8000_0000; end
            2: begin hx = 32'h8000_0000; hy = 32'h7fff_ffff; end
            default: begin
                hx = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
                hy = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            end
        endcase
        return {hx, hy};
    endfunction

    // Check each result word against the oldest expectation
    always @(posedge clk)
    begin
        curve_sample_t e;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("result word with nothing expected");
                failed = 1'b1;
            end
            else
            begin
                e = expected_samples.pop_front();
                if (result.point_x !== e.px)
                begin $error("point_x exp %0d got %0d", e.px, result.point_x); failed = 1'b1; end
                if (result.point_y !== e.py)
                begin $error("point_y exp %0d got %0d", e.py, result.point_y); failed = 1'b1; end
                if (result.slope_x !== e.sx)
                begin $error("slope_x exp %0d got %0d", e.sx, result.slope_x); failed = 1'b1; end
                if (result.slope_y !== e.sy)
                begin $error("slope_y exp %0d got %0d", e.sy, result.slope_y); failed = 1'b1; end
                if (result.bend_x !== e.bx)
                begin $error("bend_x exp %0d got %0d", e.bx, result.bend_x); failed = 1'b1; end
                if (result.bend_y !== e.by)
                begin $error("bend_y exp %0d got %0d", e.by, result.bend_y); failed = 1'b1; end
            end
        end
    end

    // Receiver stalls in bursts
    initial
    begin
        result.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(4) == 0)
            begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                result.ready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles with no word accepted on any channel
    always @(posedge clk)
    begin
        if ((sample.valid && sample.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Directed words: t and the point read off directly where obvious
    typedef struct {
        logic [FB:0] t;
        bit          known;
        logic [31:0] px, py;
    } t_row_t;

    localparam int DIRECTED_ROWS = 10;
    t_row_t t_rows [DIRECTED_ROWS];

    initial
    begin
        curve_sample_t s;
        for (int i = 0; i < NUM_POINTS; i++) ctrl_pts[i] = '0;
        cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
        sample.valid = 1'b0; sample.t_param = '0;
        t_rows = '{
            '{17'd0,       1'b1, 32'h1234_5678, 32'hffff_0000},
            '{17'h10000,   1'b1, 32'h8000_0000, 32'h7fff_ffff},
            '{17'h1ffff,   1'b1, 32'h8000_0000, 32'h7fff_ffff},
            '{17'h10001,   1'b1, 32'h8000_0000, 32'h7fff_ffff},
            '{17'd1,       1'b0, 0, 0},
            '{17'h0ffff,   1'b0, 0, 0},
            '{17'h08000,   1'b0, 0, 0},
            '{17'h04000,   1'b0, 0, 0},
            '{17'h0aaaa,   1'b0, 0, 0},
            '{17'h15555,   1'b1, 32'h8000_0000, 32'h7fff_ffff}
        };
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // After reset every point is zero
        send_t(17'h08000);
        drain();
        // Out-of-range index must be dropped
        write_reg(3'd6, 64'hdead_beef_dead_beef);
        write_reg(3'd7, 64'hffff_ffff_ffff_ffff);
        write_reg(REG_START_POINT,      64'h1234_5678_ffff_0000);
        write_reg(REG_CTRL_POINT_ONE,   64'h7fff_ffff_8000_0000);
        write_reg(REG_CTRL_POINT_TWO,   64'h8000_0000_7fff_ffff);
        write_reg(REG_CTRL_POINT_THREE, 64'h7fff_ffff_8000_0000);
        write_reg(REG_CTRL_POINT_FOUR,  64'h8000_0000_7fff_ffff);
        write_reg(REG_FINISH_POINT,     64'h8000_0000_7fff_ffff);
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            s = eval_curve(t_rows[i].t);
            if (t_rows[i].known && (s.px !== t_rows[i].px || s.py !== t_rows[i].py))
            begin
                $error("endpoint row %0d predicted %h %h", i, s.px, s.py);
                failed = 1'b1;
            end
            send_t(t_rows[i].t);
        end
        drain();

        // Random phases with fresh control points
        for (int ph = 0; ph < PHASES; ph++)
        begin
            for (int r = 0; r < NUM_POINTS; r++)
                write_reg(cfg_reg_t'(r), (ph == 0) ? 64'h0 : random_point(ph % 4));
            if (ph == PHASES - 1) quiet = 1'b1;
            for (int n = 0; n < RANDOM_WORDS / PHASES; n++)
            begin
                case ($urandom_range(9))
                    0: send_t(17'($urandom_range(17'h10001, 17'h1ffff)));
                    1: send_t(17'($urandom_range(0, 3)));
                    2: send_t(17'(17'h10000 - $urandom_range(0, 3)));
                    default: send_t(17'($urandom_range(0, 17'h10000)));
                endcase
            end
            drain();
            idle_burst();
        end

        if (!failed)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule : tb

`default_nettype wire
